// ===== rtl/core/fscw_pkg.sv =====
// Shared types, constants and helper functions of the FAT12 sector chain walker.
// Used by the front, queue, back part and top level; it depends on nothing.
package fscw_pkg;

    // Table store size and the widths derived from it.
    localparam int FAT_BYTES = 8192;
    localparam int FAT_AW = $clog2(FAT_BYTES);
    // Wide enough for a table index (3/2 of a 12-bit cluster, plus one) and for FAT_BYTES.
    localparam int IDX_W = 14;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // Cluster constants.
    localparam logic [11:0] ENTRY_MASK = 12'hFFF;
    localparam logic [11:0] END_MARK = 12'hFF8;
    localparam logic [11:0] FIRST_DATA_CLUSTER = 12'd2;

    // Largest cluster size that the walker honors.
    localparam logic [7:0] MAX_SPC = 8'd128;

    // Configuration register indexes.
    localparam logic [1:0] REG_SPC = 2'd0;
    localparam logic [1:0] REG_ROOT_LBA = 2'd1;
    localparam logic [1:0] REG_DATA_LBA = 2'd2;

    // Command codes of an input word.
    typedef enum logic [1:0] {
        CMD_LOAD      = 2'd0,
        CMD_OPEN_FILE = 2'd1,
        CMD_OPEN_ROOT = 2'd2,
        CMD_ADVANCE   = 2'd3
    } cmd_t;

    // One classified word as it sits in the queue.
    typedef struct packed {
        cmd_t        cmd;
        logic        load_ok;
        logic [12:0] fat_offset;
        logic [7:0]  fat_byte;
        logic [11:0] start_cluster;
    } item_t;

    // Volume geometry held by the configuration registers.
    typedef struct packed {
        logic [7:0]  spc;
        logic [31:0] root_base_lba;
        logic [31:0] data_start_lba;
    } cfg_t;

    // Queue fill status.
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // Cluster size as used in the arithmetic: zero acts as one, large values clamp.
    function automatic logic [7:0] eff_spc(input logic [7:0] spc);
        logic [7:0] r;
        if (spc == 8'd0)
            r = 8'd1;
        else if (spc > MAX_SPC)
            r = MAX_SPC;
        else
            r = spc;
        return r;
    endfunction

    // Unpack a 12-bit table entry from its byte pair.
    function automatic logic [11:0] unpack_entry(input logic [15:0] pair, input logic odd);
        logic [11:0] r;
        if (odd)
            r = pair[15:4] & ENTRY_MASK;
        else
            r = pair[11:0] & ENTRY_MASK;
        return r;
    endfunction

endpackage

// ===== rtl/core/fscw_if.sv =====
// Channel interfaces of the FAT12 sector chain walker: command words in, sector words out.
// Depends on nothing; the payload widths follow the block's field list.

// Command channel.
interface fscw_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [12:0] fat_offset;
    logic [7:0]  fat_byte;
    logic [11:0] start_cluster;

    modport source (output valid, command, fat_offset, fat_byte, start_cluster, input ready);
    modport sink (input valid, command, fat_offset, fat_byte, start_cluster, output ready);
endinterface

// Result channel.
interface fscw_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] sector_lba;
    logic        end_of_chain;

    modport source (output valid, sector_lba, end_of_chain, input ready);
    modport sink (input valid, sector_lba, end_of_chain, output ready);
endinterface

// ===== rtl/core/fscw_front.sv =====
// Front part: accepts command words and classifies them for the queue.
// Depends on fscw_pkg and fscw_req_if.
module fscw_front (
    fscw_req_if.sink          req,
    input  fscw_pkg::q_stat_t q_stat,
    output logic              push,
    output fscw_pkg::item_t   item
);

    // A word is taken whenever the queue has room.
    assign req.ready = !q_stat.full;
    assign push = req.valid && !q_stat.full;

    // Decode the command and check the load offset against the table size.
    always_comb
    begin
        item.cmd = fscw_pkg::cmd_t'(req.command);
        item.load_ok = ({1'b0, req.fat_offset} < fscw_pkg::IDX_W'(fscw_pkg::FAT_BYTES));
        item.fat_offset = req.fat_offset;
        item.fat_byte = req.fat_byte;
        item.start_cluster = req.start_cluster;
    end

endmodule

// ===== rtl/core/fscw_queue.sv =====
// Short queue of classified words between the front and the back part.
// Depends on fscw_pkg.
module fscw_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  fscw_pkg::item_t   push_item,
    input  logic              pop,
    output fscw_pkg::item_t   head,
    output fscw_pkg::q_stat_t stat
);

    fscw_pkg::item_t entry_reg [fscw_pkg::QUEUE_DEPTH];
    logic [fscw_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [fscw_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [fscw_pkg::QCNT_W-1:0] count_reg, count_next;

    // Pointer and count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            if (wr_ptr_reg == fscw_pkg::QPTR_W'(fscw_pkg::QUEUE_DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            if (rd_ptr_reg == fscw_pkg::QPTR_W'(fscw_pkg::QUEUE_DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

    assign head = entry_reg[rd_ptr_reg];
    assign stat.full = (count_reg == fscw_pkg::QCNT_W'(fscw_pkg::QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

// ===== rtl/core/fscw_back.sv =====
// Back part: holds the walk state and the table store, carries out each command
// and drives the result register. Depends on fscw_pkg and fscw_rsp_if.
module fscw_back (
    input  logic            clk,
    input  logic            rst_n,
    input  fscw_pkg::cfg_t  cfg,
    input  fscw_pkg::item_t head,
    input  logic            q_empty,
    output logic            pop,
    fscw_rsp_if.source      rsp
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_RD_LO = 7'b0000010,
        ST_RD_HI = 7'b0000100,
        ST_NEXT  = 7'b0001000,
        ST_MUL   = 7'b0010000,
        ST_ADD   = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // Walk state.
    logic [11:0] cluster_reg, cluster_next;
    logic [31:0] root_sector_reg, root_sector_next;
    logic [6:0]  sic_reg, sic_next;
    logic        walking_root_reg, walking_root_next;

    // Datapath registers.
    logic [7:0]  lo_byte_reg, lo_byte_next;
    logic [31:0] prod_reg, prod_next;
    logic [31:0] res_lba_reg, res_lba_next;
    logic        res_eoc_reg, res_eoc_next;

    // Result register.
    logic        rsp_valid_reg, rsp_valid_next;
    logic [31:0] rsp_lba_reg;
    logic        rsp_eoc_reg;
    logic        rsp_load;

    // Table store.
    logic [7:0] fat_mem [fscw_pkg::FAT_BYTES];
    logic [7:0] rd_data;
    logic [fscw_pkg::FAT_AW-1:0] rd_addr;
    logic       mem_we;

    logic [7:0]  spc_eff;
    logic [7:0]  sic_inc;
    logic [fscw_pkg::IDX_W-1:0] idx_lo, idx_hi;
    logic        lo_ok, hi_ok;
    logic [7:0]  hi_byte;
    logic [11:0] next_cluster;
    logic [31:0] cluster_off;

    assign spc_eff = fscw_pkg::eff_spc(cfg.spc);
    assign sic_inc = {1'b0, sic_reg} + 8'd1;

    // Byte index of the current cluster's entry: cluster * 3 / 2.
    assign idx_lo = {2'b00, cluster_reg} + {3'b000, cluster_reg[11:1]};
    assign idx_hi = idx_lo + 1'b1;
    assign lo_ok = (idx_lo < fscw_pkg::IDX_W'(fscw_pkg::FAT_BYTES));
    assign hi_ok = (idx_hi < fscw_pkg::IDX_W'(fscw_pkg::FAT_BYTES));
    assign rd_addr = (state_reg == ST_RD_HI) ? idx_hi[fscw_pkg::FAT_AW-1:0]
                                             : idx_lo[fscw_pkg::FAT_AW-1:0];
    assign hi_byte = hi_ok ? rd_data : 8'd0;
    assign next_cluster = fscw_pkg::unpack_entry({hi_byte, lo_byte_reg}, cluster_reg[0]);

    // Cluster offset from the start of the data area, wrapping below cluster two.
    assign cluster_off = {20'd0, cluster_reg} - {20'd0, fscw_pkg::FIRST_DATA_CLUSTER};

    assign pop = (state_reg == ST_IDLE) && !q_empty;
    assign mem_we = pop && (head.cmd == fscw_pkg::CMD_LOAD) && head.load_ok;
    assign rsp_load = (state_reg == ST_EMIT) && (!rsp_valid_reg || rsp.ready);

    // Table store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            fat_mem[head.fat_offset[fscw_pkg::FAT_AW-1:0]] <= head.fat_byte;
        rd_data <= fat_mem[rd_addr];
    end

    // Command sequencer.
    always_comb
    begin
        state_next = state_reg;
        cluster_next = cluster_reg;
        root_sector_next = root_sector_reg;
        sic_next = sic_reg;
        walking_root_next = walking_root_reg;
        lo_byte_next = lo_byte_reg;
        prod_next = prod_reg;
        res_lba_next = res_lba_reg;
        res_eoc_next = res_eoc_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    unique case (head.cmd)
                        fscw_pkg::CMD_LOAD:
                        begin
                            state_next = ST_IDLE;
                        end
                        fscw_pkg::CMD_OPEN_FILE:
                        begin
                            cluster_next = head.start_cluster;
                            sic_next = '0;
                            walking_root_next = 1'b0;
                            state_next = ST_MUL;
                        end
                        fscw_pkg::CMD_OPEN_ROOT:
                        begin
                            root_sector_next = cfg.root_base_lba;
                            walking_root_next = 1'b1;
                            res_lba_next = cfg.root_base_lba;
                            res_eoc_next = 1'b0;
                            state_next = ST_EMIT;
                        end
                        fscw_pkg::CMD_ADVANCE:
                        begin
                            priority if (walking_root_reg)
                            begin
                                root_sector_next = root_sector_reg + 32'd1;
                                res_lba_next = root_sector_reg + 32'd1;
                                res_eoc_next = 1'b0;
                                state_next = ST_EMIT;
                            end
                            else if (cluster_reg >= fscw_pkg::END_MARK)
                            begin
                                res_lba_next = '0;
                                res_eoc_next = 1'b1;
                                state_next = ST_EMIT;
                            end
                            else if (sic_inc >= spc_eff)
                            begin
                                sic_next = '0;
                                state_next = ST_RD_LO;
                            end
                            else
                            begin
                                sic_next = sic_inc[6:0];
                                state_next = ST_MUL;
                            end
                        end
                    endcase
                end
            end
            ST_RD_LO:
            begin
                state_next = ST_RD_HI;
            end
            ST_RD_HI:
            begin
                lo_byte_next = lo_ok ? rd_data : 8'd0;
                state_next = ST_NEXT;
            end
            ST_NEXT:
            begin
                cluster_next = next_cluster;
                if (next_cluster >= fscw_pkg::END_MARK)
                begin
                    res_lba_next = '0;
                    res_eoc_next = 1'b1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next = cluster_off * {24'd0, spc_eff};
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                res_lba_next = cfg.data_start_lba + prod_reg + {25'd0, sic_reg};
                res_eoc_next = 1'b0;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (rsp_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result register valid flag.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
            rsp_valid_next = 1'b1;
        else if (rsp.ready)
            rsp_valid_next = 1'b0;
    end

    // Control and walk state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cluster_reg <= '0;
            root_sector_reg <= '0;
            sic_reg <= '0;
            walking_root_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cluster_reg <= cluster_next;
            root_sector_reg <= root_sector_next;
            sic_reg <= sic_next;
            walking_root_reg <= walking_root_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Datapath and result payload.
    always_ff @(posedge clk)
    begin
        lo_byte_reg <= lo_byte_next;
        prod_reg <= prod_next;
        res_lba_reg <= res_lba_next;
        res_eoc_reg <= res_eoc_next;
        if (rsp_load)
        begin
            rsp_lba_reg <= res_lba_reg;
            rsp_eoc_reg <= res_eoc_reg;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.sector_lba = rsp_lba_reg;
    assign rsp.end_of_chain = rsp_eoc_reg;

endmodule

// ===== rtl/core/fat12_sector_chain_walker.sv =====
// Top level of the FAT12 sector chain walker: configuration registers, front,
// queue and back part. Depends on fscw_pkg, fscw_if, fscw_front, fscw_queue, fscw_back.
//
// Usage:
//   req carries command words (load table byte, open file, open root, advance);
//   a word is taken when req.valid and req.ready are high at a clock edge.
//   rsp carries one word per open or advance command: sector_lba and
//   end_of_chain. Load commands give no result word.
//   cfg_we/cfg_index/cfg_data write the cluster size (0), the root directory
//   start (1) and the data area start (2); write them only while
//   the block is idle.
// Command handling:
//   Words enter a two-deep queue, and the back part works one word at a time.
//   A load writes the table store as it is popped; a root open, a root advance
//   or an advance past the end of the chain goes straight to the result; a file
//   open or an advance inside a cluster passes the registered multiply and the
//   address add; an advance that crosses into the next cluster first reads the
//   entry's two bytes through the table store's one registered read port, then
//   ends the chain or passes the registered multiply and the address add.
// Reset: rst_n clears the walk state and the channels and restores the
//   registers to 1, 19 and 33. Table bytes are undefined until loaded.
// Stalls: a result waits in the output register while rsp.ready is low; the
//   back then waits, and req.ready drops once the queue is full.
module fat12_sector_chain_walker (
    input  logic        clk,
    input  logic        rst_n,
    fscw_req_if.sink    req,
    fscw_rsp_if.source  rsp,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    fscw_pkg::cfg_t    cfg_reg, cfg_next;
    fscw_pkg::q_stat_t q_stat;
    fscw_pkg::item_t   push_item;
    fscw_pkg::item_t   head;
    logic              push;
    logic              pop;

    // Configuration register writes; an index beyond the list is ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                fscw_pkg::REG_SPC:      cfg_next.spc = cfg_data[7:0];
                fscw_pkg::REG_ROOT_LBA: cfg_next.root_base_lba = cfg_data;
                fscw_pkg::REG_DATA_LBA: cfg_next.data_start_lba = cfg_data;
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.spc <= 8'd1;
            cfg_reg.root_base_lba <= 32'd19;
            cfg_reg.data_start_lba <= 32'd33;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front part: take and classify command words.
    fscw_front u_front (
        .req    (req),
        .q_stat (q_stat),
        .push   (push),
        .item   (push_item)
    );

    // Queue between front and back.
    fscw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .stat      (q_stat)
    );

    // Back part: walk state, table store and result register.
    fscw_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .head    (head),
        .q_empty (q_stat.empty),
        .pop     (pop),
        .rsp     (rsp)
    );

`ifndef ASSERT_OFF
    // An end-of-chain word always carries a zero sector address.
    a_eoc_zero_lba: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.end_of_chain |-> rsp.sector_lba == 32'd0)
        else $error("end_of_chain word with nonzero sector_lba");

    // The queue can never be full and empty at once.
    a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty together");

    // No command word is taken while the queue is full.
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> !req.ready)
        else $error("command word taken into a full queue");

    // The back only pops a word that the queue holds.
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from an empty queue");
`endif

endmodule
